/* hdl/shtf_pkg.sv */
// shtf_pkg: shared constants, types and character helpers for the simhash
// text fingerprint block; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package shtf_pkg;

    // default sizes handed to the top level
    localparam int HASH_BITS_DEF  = 64;
    localparam int COUNT_BITS_DEF = 24;

    // fixed port widths
    localparam int BYTE_BITS = 8;
    localparam int FP_BITS   = 64;
    localparam int WC_BITS   = 24;

    // saturating bit counter width
    localparam int CTR_BITS = 26;

    // polynomial hash constants
    localparam int HASH_MULT = 197;
    localparam int CHAR_BIAS = 96;

    // per-word control from the hash stage to the counter bank
    typedef struct packed {
        logic step;   // a byte is processed this cycle
        logic close;  // a word closes on this byte
        logic clear;  // last byte of the document: return to reset state
    } ctr_ctrl_t;

    // fold A-Z to lower case
    function automatic logic [BYTE_BITS-1:0] fold_case(input logic [BYTE_BITS-1:0] c);
        logic [BYTE_BITS-1:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            r = c | 8'h20;
        end
        return r;
    endfunction

    // digits and a-z are word characters, everything else delimits
    function automatic logic is_word_char(input logic [BYTE_BITS-1:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

endpackage

`default_nettype wire

/* hdl/shtf_word_hash.sv */
// shtf_word_hash: character classing and running polynomial word hash
// depends on shtf_pkg
`timescale 1ns / 1ps
`default_nettype none

module shtf_word_hash #(
    parameter int HASH_BITS = shtf_pkg::HASH_BITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           step,
    input  wire logic [shtf_pkg::BYTE_BITS-1:0] text_byte,
    input  wire logic                           doc_end,
    output shtf_pkg::ctr_ctrl_t                 ctrl,
    output logic [HASH_BITS-1:0]                close_hash
);
    import shtf_pkg::*;

    localparam logic [HASH_BITS-1:0] MULT = HASH_BITS'(HASH_MULT);
    localparam logic [BYTE_BITS-1:0] BIAS = BYTE_BITS'(CHAR_BIAS);

    logic [HASH_BITS-1:0] hash_reg, hash_next;
    logic [HASH_BITS-1:0] power_reg, power_next;
    logic                 in_word_reg, in_word_next;

    logic [BYTE_BITS-1:0] c;
    logic                 wc;
    logic                 neg;
    logic [BYTE_BITS-1:0] diff;
    logic [HASH_BITS-1:0] prod;
    logic [HASH_BITS-1:0] delta;
    logic [HASH_BITS-1:0] sum;
    logic                 close;

    // classify and form the signed character weight (c - 96)
    always_comb
    begin
        c    = fold_case(text_byte);
        wc   = is_word_char(c);
        neg  = c < BIAS;
        diff = neg ? (BIAS - c) : (c - BIAS);
    end

    // weight times current power, negated for digits
    always_comb
    begin
        prod  = power_reg * HASH_BITS'(diff[5:0]);
        delta = neg ? (~prod + HASH_BITS'(1)) : prod;
        sum   = hash_reg + delta;
    end

    // word close: at a delimiter inside a word, or at document end on a word character or with an open word
    always_comb
    begin
        close      = (!wc && in_word_reg) || (doc_end && (wc || in_word_reg));
        close_hash = wc ? sum : hash_reg;
        ctrl.step  = step;
        ctrl.close = close;
        ctrl.clear = doc_end;
    end

    // next hash state
    always_comb
    begin
        hash_next    = hash_reg;
        power_next   = power_reg;
        in_word_next = in_word_reg;
        if (step)
        begin
            if (close || doc_end)
            begin
                hash_next    = '0;
                power_next   = HASH_BITS'(1);
                in_word_next = 1'b0;
            end
            else if (wc)
            begin
                hash_next    = sum;
                power_next   = power_reg * MULT;
                in_word_next = 1'b1;
            end
        end
    end

    // hash registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg    <= '0;
            power_reg   <= HASH_BITS'(1);
            in_word_reg <= 1'b0;
        end
        else
        begin
            hash_reg    <= hash_next;
            power_reg   <= power_next;
            in_word_reg <= in_word_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/shtf_counter_bank.sv */
// shtf_counter_bank: saturating per-bit vote counters and word counter
// depends on shtf_pkg
`timescale 1ns / 1ps
`default_nettype none

module shtf_counter_bank #(
    parameter int HASH_BITS  = shtf_pkg::HASH_BITS_DEF,
    parameter int COUNT_BITS = shtf_pkg::COUNT_BITS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire shtf_pkg::ctr_ctrl_t  ctrl,
    input  wire logic [HASH_BITS-1:0] close_hash,
    output logic [HASH_BITS-1:0]      fp_bits,
    output logic [COUNT_BITS-1:0]     words_now
);
    import shtf_pkg::*;

    localparam logic [CTR_BITS-1:0]   CTR_MAX   = {1'b0, {(CTR_BITS-1){1'b1}}};
    localparam logic [CTR_BITS-1:0]   CTR_MIN   = {1'b1, {(CTR_BITS-1){1'b0}}};
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    logic [CTR_BITS-1:0]   ctr_reg  [HASH_BITS];
    logic [CTR_BITS-1:0]   ctr_next [HASH_BITS];
    logic [CTR_BITS-1:0]   ctr_step [HASH_BITS];
    logic [COUNT_BITS-1:0] words_reg, words_next;

    // one saturating up/down step per counter, sign gives the fingerprint bit
    always_comb
    begin
        for (int j = 0; j < HASH_BITS; j++)
        begin
            ctr_step[j] = ctr_reg[j];
            if (ctrl.close)
            begin
                if (close_hash[j])
                begin
                    if (ctr_reg[j] != CTR_MAX)
                    begin
                        ctr_step[j] = ctr_reg[j] + CTR_BITS'(1);
                    end
                end
                else if (ctr_reg[j] != CTR_MIN)
                begin
                    ctr_step[j] = ctr_reg[j] - CTR_BITS'(1);
                end
            end
            fp_bits[j]  = ~ctr_step[j][CTR_BITS-1];
            ctr_next[j] = ctr_reg[j];
            if (ctrl.step)
            begin
                ctr_next[j] = ctrl.clear ? '0 : ctr_step[j];
            end
        end
    end

    // saturating word count
    always_comb
    begin
        words_now = words_reg;
        if (ctrl.close && words_reg != COUNT_MAX)
        begin
            words_now = words_reg + COUNT_BITS'(1);
        end
        words_next = words_reg;
        if (ctrl.step)
        begin
            words_next = ctrl.clear ? '0 : words_now;
        end
    end

    // counter registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < HASH_BITS; j++)
            begin
                ctr_reg[j] <= '0;
            end
            words_reg <= '0;
        end
        else
        begin
            for (int j = 0; j < HASH_BITS; j++)
            begin
                ctr_reg[j] <= ctr_next[j];
            end
            words_reg <= words_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/simhash_text_fingerprint.sv */
// simhash_text_fingerprint: top level, input register, output register
// depends on shtf_pkg, shtf_word_hash, shtf_counter_bank
// A byte with tlast waits for a free result slot, then its fingerprint word is registered.
// Throughput: one byte per cycle; the hash multiply-add and the counter
// update feed their registers directly, and a pending result blocks only a byte with tlast.
// Reset: asynchronous active-low rst_n clears all counters, hash state and
// valid flags at once; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module simhash_text_fingerprint #(
    parameter int HASH_BITS  = shtf_pkg::HASH_BITS_DEF,
    parameter int COUNT_BITS = shtf_pkg::COUNT_BITS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // s_tdata: text_byte[7:0]
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [7:0]                   s_tdata,
    input  wire logic                         s_tlast,
    // m_tdata: fingerprint[63:0], word_count[87:64]
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [87:0]                       m_tdata
);
    import shtf_pkg::*;

    logic                 in_valid_reg, in_valid_next;
    logic [BYTE_BITS-1:0] in_byte_reg;
    logic                 in_last_reg;

    logic                 out_valid_reg, out_valid_next;
    logic [FP_BITS-1:0]   out_fp_reg;
    logic [WC_BITS-1:0]   out_wc_reg;

    logic                 out_free;
    logic                 advance;

    ctr_ctrl_t             ctrl;
    logic [HASH_BITS-1:0]  close_hash;
    logic [HASH_BITS-1:0]  fp_bits;
    logic [COUNT_BITS-1:0] words_now;

    // handshake: a held byte moves on unless it ends a document and the result slot is full
    always_comb
    begin
        out_free       = !out_valid_reg || m_tready;
        advance        = in_valid_reg && (!in_last_reg || out_free);
        s_tready       = !in_valid_reg || advance;
        in_valid_next  = s_tvalid ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        out_valid_next = (advance && in_last_reg) ? 1'b1 :
                         (m_tready ? 1'b0 : out_valid_reg);
    end

    shtf_word_hash #(
        .HASH_BITS(HASH_BITS)
    ) u_word_hash (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance),
        .text_byte  (in_byte_reg),
        .doc_end    (in_last_reg),
        .ctrl       (ctrl),
        .close_hash (close_hash)
    );

    shtf_counter_bank #(
        .HASH_BITS  (HASH_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_counter_bank (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .close_hash (close_hash),
        .fp_bits    (fp_bits),
        .words_now  (words_now)
    );

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= in_valid_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // input byte register
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (advance && in_last_reg)
        begin
            out_fp_reg <= FP_BITS'(fp_bits);
            out_wc_reg <= WC_BITS'(words_now);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_wc_reg, out_fp_reg};

endmodule

`default_nettype wire
